/* rtl/assert_macros.svh */
// Assertion macros used by the sorter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define DFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define DFS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/dfs_pkg.sv */
// Shared codes, state type and helpers of the depth-first topological sorter.
package dfs_pkg;

  localparam int VW = 9;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_ADD   = 2'd1;
  localparam logic [1:0] FUNC_SORT  = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  typedef enum logic [11:0] {
    S_IDLE      = 12'b0000_0000_0001,
    S_SWEEP     = 12'b0000_0000_0010,
    S_ROOT      = 12'b0000_0000_0100,
    S_ROOT_CHK  = 12'b0000_0000_1000,
    S_EDGE      = 12'b0000_0001_0000,
    S_EDGE_RD   = 12'b0000_0010_0000,
    S_TGT       = 12'b0000_0100_0000,
    S_POP       = 12'b0000_1000_0000,
    S_ADD       = 12'b0001_0000_0000,
    S_ADD_WR    = 12'b0010_0000_0000,
    S_READ      = 12'b0100_0000_0000,
    S_READ_WAIT = 12'b1000_0000_0000
  } state_t;

  // A vertex number is in use when it lies in 1..cnt.
  function automatic logic in_range(input logic [VW-1:0] v, input logic [VW-1:0] cnt);
    in_range = (v != '0) && (v <= cnt);
  endfunction

endpackage

/* rtl/dfs_ram.sv */
// Simple dual-port RAM: one write port, one read port with registered data.
module dfs_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/dfs_topological_order.sv */
// Depth-first topological sorter over a linked edge store, one step per cycle.
// The single read port of each RAM sets the pace, and one item is in flight at a time.
// After reset a clearing pass over all vertex entries empties the lists before any beat.
`include "assert_macros.svh"
module dfs_topological_order #(
  parameter int MAX_NODES = 256,
  parameter int MAX_EDGES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // source_vertex[8:0], target_vertex[17:9], zero pad
  input  logic [1:0]  in_tuser,    // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // status[1:0], position[10:2], zero pad
  input  logic        cfg_wr_en,
  input  logic [8:0]  cfg_wr_data
);

  localparam int NW  = $clog2(MAX_NODES);
  localparam int EW  = $clog2(MAX_EDGES);
  localparam int PW  = EW + 1;
  localparam int SPW = $clog2(MAX_NODES + 1);
  localparam int VW  = dfs_pkg::VW;
  localparam int FW  = VW + PW;
  localparam logic [PW-1:0] NULL_E = PW'(MAX_EDGES);

  dfs_pkg::state_t state_r, state_nxt;
  logic            clr_r, clr_nxt;
  logic            boot_r, boot_nxt;
  logic [NW-1:0]   sweep_r, sweep_nxt;
  logic [VW-1:0]   node_count_r;
  logic [PW-1:0]   edge_total_r, edge_total_nxt;
  logic [VW-1:0]   src_r, src_nxt;
  logic [VW-1:0]   dst_r, dst_nxt;
  logic [VW-1:0]   root_r, root_nxt;
  logic [VW-1:0]   cur_vtx_r, cur_vtx_nxt;
  logic [PW-1:0]   cur_nxt_r, cur_nxt_nxt;
  logic [VW-1:0]   tgt_r, tgt_nxt;
  logic [SPW-1:0]  sp_r, sp_nxt;
  logic [VW-1:0]   done_r, done_nxt;
  logic            out_tvalid_r, out_tvalid_nxt;
  logic [1:0]      out_status_r, out_status_nxt;
  logic [VW-1:0]   out_pos_r, out_pos_nxt;

  logic [VW-1:0]   cnt;
  logic [1:0]      in_func;
  logic [VW-1:0]   in_src, in_dst;
  logic            accept;

  // RAM ports.
  logic            vis_we,  vis_wd,  vis_rd;
  logic [NW-1:0]   vis_wa,  vis_ra;
  logic            pos_we;
  logic [NW-1:0]   pos_wa,  pos_ra;
  logic [VW-1:0]   pos_wd,  pos_rd;
  logic            head_we;
  logic [NW-1:0]   head_wa, head_ra;
  logic [PW-1:0]   head_wd, head_rd;
  logic            tail_we;
  logic [NW-1:0]   tail_wa, tail_ra;
  logic [PW-1:0]   tail_wd, tail_rd;
  logic            et_we;
  logic [EW-1:0]   et_wa,   et_ra;
  logic [VW-1:0]   et_wd,   et_rd;
  logic            en_we;
  logic [EW-1:0]   en_wa,   en_ra;
  logic [PW-1:0]   en_wd,   en_rd;
  logic            stk_we;
  logic [NW-1:0]   stk_wa,  stk_ra;
  logic [FW-1:0]   stk_wd,  stk_rd;

  assign in_func = in_tuser;
  assign in_src  = in_tdata[8:0];
  assign in_dst  = in_tdata[17:9];
  assign cnt     = (int'(node_count_r) > MAX_NODES) ? VW'(MAX_NODES) : node_count_r;

  // Handshakes.
  assign in_tready  = (state_r == dfs_pkg::S_IDLE) && (!out_tvalid_r || out_tready);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'd0, out_pos_r, out_status_r};

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= 9'd256;
    end else if (cfg_wr_en) begin
      node_count_r <= cfg_wr_data;
    end
  end

  // Sequencer: drives one write port and one read port per store.
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    boot_nxt       = boot_r;
    sweep_nxt      = sweep_r;
    edge_total_nxt = edge_total_r;
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    root_nxt       = root_r;
    cur_vtx_nxt    = cur_vtx_r;
    cur_nxt_nxt    = cur_nxt_r;
    tgt_nxt        = tgt_r;
    sp_nxt         = sp_r;
    done_nxt       = done_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;

    vis_we  = 1'b0; vis_wa  = sweep_r; vis_wd  = 1'b0;
    vis_ra  = NW'(root_r - 9'd1);
    pos_we  = 1'b0; pos_wa  = sweep_r; pos_wd  = '0;
    pos_ra  = NW'(src_r - 9'd1);
    head_we = 1'b0; head_wa = sweep_r; head_wd = NULL_E;
    head_ra = NW'(root_r - 9'd1);
    tail_we = 1'b0; tail_wa = sweep_r; tail_wd = NULL_E;
    tail_ra = NW'(src_r - 9'd1);
    et_we   = 1'b0; et_wa   = edge_total_r[EW-1:0]; et_wd = dst_r;
    et_ra   = cur_nxt_r[EW-1:0];
    en_we   = 1'b0; en_wa   = edge_total_r[EW-1:0]; en_wd = NULL_E;
    en_ra   = cur_nxt_r[EW-1:0];
    stk_we  = 1'b0; stk_wa  = NW'(sp_r - SPW'(1)); stk_wd = {cur_vtx_r, cur_nxt_r};
    stk_ra  = NW'(sp_r - SPW'(2));

    case (state_r)
      dfs_pkg::S_IDLE: begin
        if (accept) begin
          src_nxt = in_src;
          dst_nxt = in_dst;
          case (in_func)
            dfs_pkg::FUNC_CLEAR: begin
              clr_nxt        = 1'b1;
              sweep_nxt      = '0;
              edge_total_nxt = '0;
              state_nxt      = dfs_pkg::S_SWEEP;
            end
            dfs_pkg::FUNC_ADD: begin
              if (!dfs_pkg::in_range(in_src, cnt) || !dfs_pkg::in_range(in_dst, cnt)) begin
                out_tvalid_nxt = 1'b1;
                out_status_nxt = dfs_pkg::STAT_RANGE;
                out_pos_nxt    = '0;
              end else if (edge_total_r == NULL_E) begin
                out_tvalid_nxt = 1'b1;
                out_status_nxt = dfs_pkg::STAT_FULL;
                out_pos_nxt    = '0;
              end else begin
                state_nxt = dfs_pkg::S_ADD;
              end
            end
            dfs_pkg::FUNC_SORT: begin
              clr_nxt   = 1'b0;
              sweep_nxt = '0;
              state_nxt = dfs_pkg::S_SWEEP;
            end
            dfs_pkg::FUNC_READ: begin
              if (dfs_pkg::in_range(in_src, cnt)) begin
                state_nxt = dfs_pkg::S_READ;
              end else begin
                out_tvalid_nxt = 1'b1;
                out_status_nxt = dfs_pkg::STAT_RANGE;
                out_pos_nxt    = '0;
              end
            end
            default: ;
          endcase
        end
      end

      // Clear marks and positions; for clear and after reset also the list ends.
      dfs_pkg::S_SWEEP: begin
        vis_we  = 1'b1;
        pos_we  = 1'b1;
        head_we = clr_r;
        tail_we = clr_r;
        sweep_nxt = sweep_r + NW'(1);
        if (sweep_r == NW'(MAX_NODES - 1)) begin
          done_nxt = '0;
          root_nxt = 9'd1;
          if (boot_r) begin
            boot_nxt  = 1'b0;
            state_nxt = dfs_pkg::S_IDLE;
          end else if (clr_r || cnt == '0) begin
            out_tvalid_nxt = 1'b1;
            out_status_nxt = dfs_pkg::STAT_OK;
            out_pos_nxt    = '0;
            state_nxt      = dfs_pkg::S_IDLE;
          end else begin
            state_nxt = dfs_pkg::S_ROOT;
          end
        end
      end

      // Root lookup issued through the default read addresses.
      dfs_pkg::S_ROOT: begin
        state_nxt = dfs_pkg::S_ROOT_CHK;
      end

      dfs_pkg::S_ROOT_CHK: begin
        if (vis_rd) begin
          if (root_r == cnt) begin
            out_tvalid_nxt = 1'b1;
            out_status_nxt = dfs_pkg::STAT_OK;
            out_pos_nxt    = '0;
            state_nxt      = dfs_pkg::S_IDLE;
          end else begin
            root_nxt  = root_r + 9'd1;
            state_nxt = dfs_pkg::S_ROOT;
          end
        end else begin
          vis_we      = 1'b1;
          vis_wa      = NW'(root_r - 9'd1);
          vis_wd      = 1'b1;
          cur_vtx_nxt = root_r;
          cur_nxt_nxt = head_rd;
          sp_nxt      = SPW'(1);
          state_nxt   = dfs_pkg::S_EDGE;
        end
      end

      // Take the next edge of the top frame, or finish the vertex.
      dfs_pkg::S_EDGE: begin
        if (cur_nxt_r >= edge_total_r) begin
          pos_we   = 1'b1;
          pos_wa   = NW'(cur_vtx_r - 9'd1);
          pos_wd   = cnt - done_r;
          done_nxt = done_r + 9'd1;
          sp_nxt   = sp_r - SPW'(1);
          if (sp_r == SPW'(1)) begin
            if (root_r == cnt) begin
              out_tvalid_nxt = 1'b1;
              out_status_nxt = dfs_pkg::STAT_OK;
              out_pos_nxt    = '0;
              state_nxt      = dfs_pkg::S_IDLE;
            end else begin
              root_nxt  = root_r + 9'd1;
              state_nxt = dfs_pkg::S_ROOT;
            end
          end else begin
            state_nxt = dfs_pkg::S_POP;
          end
        end else begin
          state_nxt = dfs_pkg::S_EDGE_RD;
        end
      end

      dfs_pkg::S_EDGE_RD: begin
        cur_nxt_nxt = en_rd;
        tgt_nxt     = et_rd;
        vis_ra      = NW'(et_rd - 9'd1);
        head_ra     = NW'(et_rd - 9'd1);
        if (dfs_pkg::in_range(et_rd, cnt) && (int'(sp_r) < MAX_NODES)) begin
          state_nxt = dfs_pkg::S_TGT;
        end else begin
          state_nxt = dfs_pkg::S_EDGE;
        end
      end

      // Descend into an unvisited target, pushing the current frame.
      dfs_pkg::S_TGT: begin
        if (!vis_rd) begin
          vis_we      = 1'b1;
          vis_wa      = NW'(tgt_r - 9'd1);
          vis_wd      = 1'b1;
          stk_we      = 1'b1;
          cur_vtx_nxt = tgt_r;
          cur_nxt_nxt = head_rd;
          sp_nxt      = sp_r + SPW'(1);
        end
        state_nxt = dfs_pkg::S_EDGE;
      end

      dfs_pkg::S_POP: begin
        cur_vtx_nxt = stk_rd[FW-1:PW];
        cur_nxt_nxt = stk_rd[PW-1:0];
        state_nxt   = dfs_pkg::S_EDGE;
      end

      // Store the new edge and fetch the source's tail.
      dfs_pkg::S_ADD: begin
        et_we     = 1'b1;
        en_we     = 1'b1;
        state_nxt = dfs_pkg::S_ADD_WR;
      end

      dfs_pkg::S_ADD_WR: begin
        tail_we = 1'b1;
        tail_wa = NW'(src_r - 9'd1);
        tail_wd = edge_total_r;
        if (tail_rd < NULL_E) begin
          en_we = 1'b1;
          en_wa = tail_rd[EW-1:0];
          en_wd = edge_total_r;
        end else begin
          head_we = 1'b1;
          head_wa = NW'(src_r - 9'd1);
          head_wd = edge_total_r;
        end
        edge_total_nxt = edge_total_r + PW'(1);
        out_tvalid_nxt = 1'b1;
        out_status_nxt = dfs_pkg::STAT_OK;
        out_pos_nxt    = '0;
        state_nxt      = dfs_pkg::S_IDLE;
      end

      dfs_pkg::S_READ: begin
        state_nxt = dfs_pkg::S_READ_WAIT;
      end

      dfs_pkg::S_READ_WAIT: begin
        out_tvalid_nxt = 1'b1;
        out_status_nxt = dfs_pkg::STAT_OK;
        out_pos_nxt    = pos_rd;
        state_nxt      = dfs_pkg::S_IDLE;
      end

      default: begin
        state_nxt = dfs_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dfs_pkg::S_SWEEP;
      clr_r        <= 1'b1;
      boot_r       <= 1'b1;
      sweep_r      <= '0;
      edge_total_r <= '0;
      sp_r         <= '0;
      done_r       <= '0;
      root_r       <= 9'd1;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      boot_r       <= boot_nxt;
      sweep_r      <= sweep_nxt;
      edge_total_r <= edge_total_nxt;
      sp_r         <= sp_nxt;
      done_r       <= done_nxt;
      root_r       <= root_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    src_r        <= src_nxt;
    dst_r        <= dst_nxt;
    cur_vtx_r    <= cur_vtx_nxt;
    cur_nxt_r    <= cur_nxt_nxt;
    tgt_r        <= tgt_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
  end

  // Stores.
  dfs_ram #(.W(1), .D(MAX_NODES)) u_visited (
    .clk(clk), .we(vis_we), .waddr(vis_wa), .wdata(vis_wd), .raddr(vis_ra), .rdata(vis_rd)
  );
  dfs_ram #(.W(VW), .D(MAX_NODES)) u_position (
    .clk(clk), .we(pos_we), .waddr(pos_wa), .wdata(pos_wd), .raddr(pos_ra), .rdata(pos_rd)
  );
  dfs_ram #(.W(PW), .D(MAX_NODES)) u_head (
    .clk(clk), .we(head_we), .waddr(head_wa), .wdata(head_wd), .raddr(head_ra), .rdata(head_rd)
  );
  dfs_ram #(.W(PW), .D(MAX_NODES)) u_tail (
    .clk(clk), .we(tail_we), .waddr(tail_wa), .wdata(tail_wd), .raddr(tail_ra), .rdata(tail_rd)
  );
  dfs_ram #(.W(VW), .D(MAX_EDGES)) u_edge_target (
    .clk(clk), .we(et_we), .waddr(et_wa), .wdata(et_wd), .raddr(et_ra), .rdata(et_rd)
  );
  dfs_ram #(.W(PW), .D(MAX_EDGES)) u_edge_next (
    .clk(clk), .we(en_we), .waddr(en_wa), .wdata(en_wd), .raddr(en_ra), .rdata(en_rd)
  );
  dfs_ram #(.W(FW), .D(MAX_NODES)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd), .raddr(stk_ra), .rdata(stk_rd)
  );

  // Checks on the walk and the sequencing.
  `DFS_ASSERT(a_sp_bound, int'(sp_r) <= MAX_NODES, "walk stack overflow")
  `DFS_ASSERT(a_walk_frame, (state_r == dfs_pkg::S_EDGE) |-> (sp_r != '0), "walk without frame")
  `DFS_ASSERT(a_edges_bound, edge_total_r <= NULL_E, "edge count beyond store")
  `DFS_ASSERT(a_accept_busy, accept |=> (state_r != dfs_pkg::S_IDLE) || out_tvalid_r,
              "accepted beat left no work")
  `DFS_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_tvalid_r, "result beat out of reset")

endmodule

/* sim/tb.sv */
// Self-checking testbench for the depth-first topological sorter, with its own graph model.
module tb;

  localparam int NODES     = 256;
  localparam int EDGES     = 1024;
  localparam int CYCLE_CAP = 4000000;

  typedef struct packed {
    logic [1:0] fn;
    logic [8:0] src;
    logic [8:0] dst;
  } cmd_t;

  typedef struct packed {
    logic [1:0] st;
    logic [8:0] pos;
  } res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;    // source_vertex[8:0], target_vertex[17:9], zero pad
  logic [1:0]  in_tuser = '0;    // func[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;        // status[1:0], position[10:2], zero pad
  logic        cfg_wr_en = 1'b0;
  logic [8:0]  cfg_wr_data = '0;

  dfs_topological_order u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // Graph model state.
  logic [8:0]  count_reg = 9'd256;
  int unsigned edge_dst[EDGES];
  int unsigned edge_link[EDGES];
  int unsigned head_of[NODES];
  int unsigned tail_of[NODES];
  int unsigned edge_cnt;
  bit          seen[NODES];
  int unsigned order_pos[NODES];
  int unsigned walk_vtx[NODES];
  int unsigned walk_nxt[NODES];

  cmd_t pending_cmds[$];
  res_t expected_results[$];
  int   errors = 0;
  int   cycles = 0;
  int   rx_cycles = 0;

  initial forever #5 clk = ~clk;

  function automatic int unsigned live_count();
    return (count_reg > NODES) ? NODES : count_reg;
  endfunction

  function automatic void wipe_graph();
    for (int i = 0; i < NODES; i++) begin
      head_of[i] = EDGES;
      tail_of[i] = EDGES;
      seen[i] = 1'b0;
      order_pos[i] = 0;
    end
    edge_cnt = 0;
  endfunction

  // Iterative depth-first walk; each vertex gets its place in reversed postorder.
  function automatic void order_graph(int unsigned cnt);
    int unsigned done, sp, e, t, top;
    done = 0;
    for (int i = 0; i < NODES; i++) begin
      seen[i] = 1'b0;
      order_pos[i] = 0;
    end
    for (int unsigned v = 1; v <= cnt; v++) begin
      if (!seen[v-1]) begin
        seen[v-1] = 1'b1;
        walk_vtx[0] = v;
        walk_nxt[0] = head_of[v-1];
        sp = 1;
        while (sp > 0) begin
          top = sp - 1;
          e = walk_nxt[top];
          if (e >= edge_cnt) begin
            order_pos[walk_vtx[top]-1] = cnt - done;
            done++;
            sp--;
          end else begin
            walk_nxt[top] = edge_link[e];
            t = edge_dst[e];
            if (t >= 1 && t <= cnt && !seen[t-1] && sp < NODES) begin
              seen[t-1] = 1'b1;
              walk_vtx[sp] = t;
              walk_nxt[sp] = head_of[t-1];
              sp++;
            end
          end
        end
      end
    end
  endfunction

  function automatic res_t apply_cmd(cmd_t c);
    res_t r;
    int unsigned cnt, s;
    r = '0;
    cnt = live_count();
    case (c.fn)
      dfs_pkg::FUNC_CLEAR: wipe_graph();
      dfs_pkg::FUNC_ADD: begin
        if (c.src == 0 || c.src > cnt || c.dst == 0 || c.dst > cnt) begin
          r.st = dfs_pkg::STAT_RANGE;
        end else if (edge_cnt >= EDGES) begin
          r.st = dfs_pkg::STAT_FULL;
        end else begin
          s = c.src - 1;
          edge_dst[edge_cnt] = c.dst;
          edge_link[edge_cnt] = EDGES;
          if (tail_of[s] < EDGES) edge_link[tail_of[s]] = edge_cnt;
          else head_of[s] = edge_cnt;
          tail_of[s] = edge_cnt;
          edge_cnt++;
        end
      end
      dfs_pkg::FUNC_SORT: order_graph(cnt);
      default: begin
        if (c.src != 0 && c.src <= cnt) r.pos = 9'(order_pos[c.src-1]);
        else r.st = dfs_pkg::STAT_RANGE;
      end
    endcase
    return r;
  endfunction

  // Cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Sender: predicts each accepted beat, then offers the next one with random gaps, except in one gap-free stretch.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        expected_results = {expected_results,
                            apply_cmd({in_tuser, in_tdata[8:0], in_tdata[17:9]})};
      if (!in_tvalid || in_tready) begin
        if (pending_cmds.size() > 0 &&
            ((cycles > 6000 && cycles < 9000) || $urandom_range(99) >= 10)) begin
          cmd_t c;
          c = pending_cmds.pop_front();
          in_tuser <= c.fn;
          in_tdata <= {6'd0, c.dst, c.src};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off, and a stretch that never stalls.
  always @(posedge clk) begin
    rx_cycles <= rx_cycles + 1;
    if (rx_cycles > 2000 && rx_cycles < 2600) out_tready <= 1'b0;
    else if (rx_cycles > 6000 && rx_cycles < 9000) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(99) >= 10);
  end

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, out_tdata);
        errors++;
      end else begin
        res_t e;
        e = expected_results.pop_front();
        if (out_tdata[1:0] !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, out_tdata[1:0]);
          errors++;
        end
        if (out_tdata[10:2] !== e.pos) begin
          $display("%0t: position expected %0d actual %0d", $time, e.pos, out_tdata[10:2]);
          errors++;
        end
      end
    end
  end

  task automatic queue_cmd(logic [1:0] fn, logic [8:0] src, logic [8:0] dst);
    cmd_t c;
    c.fn = fn;
    c.src = src;
    c.dst = dst;
    pending_cmds = {pending_cmds, c};
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() > 0 || in_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_count(logic [8:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    count_reg <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly vertices in use, some just outside, some anywhere in the field.
  function automatic logic [8:0] pick_vtx();
    int unsigned cnt, r;
    cnt = live_count();
    r = $urandom_range(99);
    if (r < 80 && cnt > 0) return 9'($urandom_range(cnt, 1));
    if (r < 90) return ($urandom_range(1) != 0) ? 9'd0 : 9'(cnt + 1);
    return 9'($urandom_range(511));
  endfunction

  task automatic random_phase(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 2) queue_cmd(dfs_pkg::FUNC_CLEAR, pick_vtx(), pick_vtx());
      else if (r < 57) queue_cmd(dfs_pkg::FUNC_ADD, pick_vtx(), pick_vtx());
      else if (r < 67) queue_cmd(dfs_pkg::FUNC_SORT, pick_vtx(), pick_vtx());
      else queue_cmd(dfs_pkg::FUNC_READ, pick_vtx(), pick_vtx());
    end
  endtask

  initial begin
    logic [8:0] counts[8] = '{9'd256, 9'd8, 9'd1, 9'd0, 9'd511, 9'd2, 9'd40, 9'd256};
    wipe_graph();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    set_count(9'd256);

    // Directed: range checks, a chain, a cycle, extremes of both vertex fields.
    queue_cmd(dfs_pkg::FUNC_READ, 9'd1, 9'd0);
    queue_cmd(dfs_pkg::FUNC_ADD, 9'd1, 9'd256);
    queue_cmd(dfs_pkg::FUNC_ADD, 9'd256, 9'd1);
    queue_cmd(dfs_pkg::FUNC_ADD, 9'd1, 9'd2);
    queue_cmd(dfs_pkg::FUNC_ADD, 9'd2, 9'd3);
    queue_cmd(dfs_pkg::FUNC_ADD, 9'd0, 9'd5);
    queue_cmd(dfs_pkg::FUNC_ADD, 9'd5, 9'd0);
    queue_cmd(dfs_pkg::FUNC_ADD, 9'd257, 9'd1);
    queue_cmd(dfs_pkg::FUNC_ADD, 9'd511, 9'd511);
    queue_cmd(dfs_pkg::FUNC_READ, 9'd0, 9'd0);
    queue_cmd(dfs_pkg::FUNC_READ, 9'd257, 9'd0);
    queue_cmd(dfs_pkg::FUNC_SORT, 9'd511, 9'd511);
    queue_cmd(dfs_pkg::FUNC_READ, 9'd1, 9'd511);
    queue_cmd(dfs_pkg::FUNC_READ, 9'd2, 9'd0);
    queue_cmd(dfs_pkg::FUNC_READ, 9'd3, 9'd0);
    queue_cmd(dfs_pkg::FUNC_READ, 9'd256, 9'd0);
    queue_cmd(dfs_pkg::FUNC_ADD, 9'd3, 9'd1);
    queue_cmd(dfs_pkg::FUNC_SORT, 9'd0, 9'd0);
    queue_cmd(dfs_pkg::FUNC_READ, 9'd1, 9'd0);
    queue_cmd(dfs_pkg::FUNC_READ, 9'd100, 9'd0);
    queue_cmd(dfs_pkg::FUNC_CLEAR, 9'd511, 9'd511);
    queue_cmd(dfs_pkg::FUNC_READ, 9'd1, 9'd0);
    wait_idle();

    // Random phases over several vertex counts; edges survive a count change.
    foreach (counts[k]) begin
      set_count(counts[k]);
      random_phase(15);
      wait_idle();
    end

    // Fill the edge store past its capacity, then sort and read back.
    set_count(9'd16);
    queue_cmd(dfs_pkg::FUNC_CLEAR, 9'd0, 9'd0);
    for (int i = 0; i < EDGES + 6; i++)
      queue_cmd(dfs_pkg::FUNC_ADD, 9'($urandom_range(16, 1)), 9'($urandom_range(16, 1)));
    queue_cmd(dfs_pkg::FUNC_ADD, 9'd17, 9'd1);
    queue_cmd(dfs_pkg::FUNC_SORT, 9'd0, 9'd0);
    for (int i = 0; i <= 17; i++) queue_cmd(dfs_pkg::FUNC_READ, 9'(i), 9'd0);
    wait_idle();

    repeat (50) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
